@@ hdl/mmh_pkg.sv @@
// Shared constants, types and helpers for the MurmurHash64A engine.
// No dependencies; mmh_mul and the top level import this package.
`timescale 1ns / 1ps

package mmh_pkg;

	localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT = 47;

	// Request from the sequencer to the shared multiplier.
	typedef struct packed {
		logic        start;
		logic [63:0] operand;
	} mmh_mul_req_t;

	// Answer from the shared multiplier: done pulses for one cycle.
	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mmh_mul_rsp_t;

	// Mask that keeps the low cnt bytes of a word (cnt from 0 to 7).
	function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[i*8 +: 8] = (3'(i) < cnt) ? 8'hff : 8'h00;
		end
		return m;
	endfunction

	// The xor-shift step of the mix and of the finalizer.
	function automatic logic [63:0] xor_shift(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

endpackage

@@ hdl/mmh_if.sv @@
// Handshake channels of the MurmurHash64A engine: input words, results, seed writes.
// Depends on nothing but the language; used by the top level.
`timescale 1ns / 1ps

interface mmh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic        first_item;
	logic        last_item;
	logic [31:0] message_length;

	modport source (output valid, data_word, valid_bytes, first_item, last_item,
		message_length, input ready);
	modport sink (input valid, data_word, valid_bytes, first_item, last_item,
		message_length, output ready);
endinterface

interface mmh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

interface mmh_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_seed;

	modport source (output valid, hash_seed, input ready);
	modport sink (input valid, hash_seed, output ready);
endinterface

@@ hdl/mmh_mul.sv @@
// Shared 64-bit multiplier by the mix constant, low 64 bits of the product.
// Built from one 32x32 multiplier; depends on mmh_pkg.
`timescale 1ns / 1ps

module mmh_mul
	import mmh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  mmh_mul_req_t req,
	output mmh_mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [63:0] pp_q;
	logic [1:0]  ph_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] mul_x;
	logic [31:0] mul_y;

	// Partial products in order: a_lo*m_lo, a_lo*m_hi, a_hi*m_lo.
	// The a_hi*m_hi term falls above bit 63 and is never formed.
	always_comb begin
		case (ph_q)
			2'd0: begin
				mul_x = a_q[31:0];
				mul_y = MIX_MULT[31:0];
			end
			2'd1: begin
				mul_x = a_q[31:0];
				mul_y = MIX_MULT[63:32];
			end
			default: begin
				mul_x = a_q[63:32];
				mul_y = MIX_MULT[31:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end
		pp_q <= {32'b0, mul_x} * {32'b0, mul_y};
		if (busy_q) begin
			case (ph_q)
				2'd0:    acc_q <= acc_q;
				2'd1:    acc_q <= pp_q;
				default: acc_q <= acc_q + {pp_q[31:0], 32'b0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ph_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule

@@ hdl/murmur64a_hash_engine.sv @@
// Top level of the MurmurHash64A streaming hash engine.
// Depends on mmh_pkg, the channels in mmh_if and the shared multiplier mmh_mul.
`timescale 1ns / 1ps

// The engine hashes one message that arrives as little-endian 64-bit words on
// data_in, one word per handshake. The first word of a message carries the
// total byte length, which reseeds the running hash as seed xor (length * M).
// A full word is mixed and folded into the hash, a word of 1 to 7 bytes
// is masked to its valid bytes, xored in and multiplied, and a word with a byte count of 0
// leaves the hash alone. On the last word the hash is finalized and the 64-bit
// result is offered on hash_out; the result sits in an output register, so
// the next word can be taken while it waits. The seed is written through cfg,
// which is always ready; write it only while the engine is idle. All the
// arithmetic runs on one shared multiplier by the mix constant. data_in is not
// ready again until a word's multiplications are done: one to seed on a first
// word, three for a full word, one for a partial word, and one to finalize on a
// last word; a last word then also hands its result to the output register.
// That hand-over waits for as long as the previous result still sits
// unaccepted in the output register.
module murmur64a_hash_engine
	import mmh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mmh_in_if.sink    data_in,
	mmh_out_if.source hash_out,
	mmh_cfg_if.sink   cfg
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LOAD = 8'b0000_0010,
		S_SEED = 8'b0000_0100,
		S_K1   = 8'b0000_1000,
		S_K2   = 8'b0001_0000,
		S_HM   = 8'b0010_0000,
		S_FIN  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t       state_q;
	state_t       state_d;
	mmh_mul_req_t mul_req;
	mmh_mul_rsp_t mul_rsp;

	// Word captured at acceptance.
	logic [63:0] word_q;
	logic [2:0]  cnt_q;
	logic        full_q;
	logic        first_q;
	logic        last_q;
	logic [31:0] len_q;

	logic [31:0] seed_q;
	logic [63:0] hash_q;
	logic [63:0] hash_d;
	logic        hash_load;
	logic [63:0] fin_q;
	logic        fin_load;
	logic        out_valid_q;
	logic [63:0] out_hash_q;
	logic        out_load;

	logic        route;
	logic [63:0] route_hash;
	logic        in_accept;

	assign in_accept     = data_in.valid && data_in.ready;
	assign data_in.ready = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	mmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Sequencer. Once the running hash for this word is known (after seeding,
	// or straight from the stored value), the word is routed to the full mix,
	// the tail fold, the finalizer, or back to idle.
	always_comb begin
		state_d         = state_q;
		mul_req.start   = 1'b0;
		mul_req.operand = '0;
		hash_load       = 1'b0;
		hash_d          = hash_q;
		fin_load        = 1'b0;
		out_load        = 1'b0;
		route           = 1'b0;
		route_hash      = hash_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (first_q) begin
					mul_req.start   = 1'b1;
					mul_req.operand = {32'b0, len_q};
					state_d         = S_SEED;
				end else begin
					route = 1'b1;
				end
			end
			S_SEED: begin
				if (mul_rsp.done) begin
					route      = 1'b1;
					route_hash = {32'b0, seed_q} ^ mul_rsp.product;
				end
			end
			S_K1: begin
				if (mul_rsp.done) begin
					mul_req.start   = 1'b1;
					mul_req.operand = xor_shift(mul_rsp.product);
					state_d         = S_K2;
				end
			end
			S_K2: begin
				if (mul_rsp.done) begin
					mul_req.start   = 1'b1;
					mul_req.operand = hash_q ^ mul_rsp.product;
					state_d         = S_HM;
				end
			end
			S_HM: begin
				if (mul_rsp.done) begin
					hash_load = 1'b1;
					hash_d    = mul_rsp.product;
					if (last_q) begin
						mul_req.start   = 1'b1;
						mul_req.operand = xor_shift(mul_rsp.product);
						state_d         = S_FIN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_FIN: begin
				if (mul_rsp.done) begin
					fin_load = 1'b1;
					state_d  = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || hash_out.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (route) begin
			hash_load = 1'b1;
			hash_d    = route_hash;
			if (full_q) begin
				mul_req.start   = 1'b1;
				mul_req.operand = word_q;
				state_d         = S_K1;
			end else if (cnt_q != 3'd0) begin
				mul_req.start   = 1'b1;
				mul_req.operand = route_hash ^ (word_q & tail_mask(cnt_q));
				state_d         = S_HM;
			end else if (last_q) begin
				mul_req.start   = 1'b1;
				mul_req.operand = xor_shift(route_hash);
				state_d         = S_FIN;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			word_q  <= data_in.data_word;
			full_q  <= data_in.valid_bytes[3];
			cnt_q   <= data_in.valid_bytes[2:0];
			first_q <= data_in.first_item;
			last_q  <= data_in.last_item;
			len_q   <= data_in.message_length;
		end
		if (fin_load) begin
			fin_q <= xor_shift(mul_rsp.product);
		end
		if (out_load) begin
			out_hash_q <= fin_q;
		end
	end

	// Control state resets to idle; the seed, the running hash and the output valid reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed_q      <= '0;
			hash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				seed_q <= cfg.hash_seed;
			end
			if (hash_load) begin
				hash_q <= hash_d;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (hash_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign hash_out.valid      = out_valid_q;
	assign hash_out.hash_value = out_hash_q;

endmodule
